// ===== sv/schs_pkg.sv =====
// ----------------------------------------------------------------------------
// schs_pkg
// Types and constants shared by the spatial chunk hash store modules.
// ----------------------------------------------------------------------------
package schs_pkg;
   localparam int CoordBits = 32;
   localparam logic [31:0] HashSeed = 32'd17;
   localparam logic [31:0] HashMul = 32'd31;
   localparam logic [31:0] HashMask = 32'h7FFF_FFFF;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_CHUNK_FULL = 2'd2;
   localparam logic [1:0] STATUS_BLOCK_FULL = 2'd3;

   localparam logic REQ_STORE = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   // status sits in the lowest bits
   typedef struct packed {
      logic new_block;
      logic new_chunk;
      logic [3:0] entity_slot;
      logic [11:0] block_index;
      logic [9:0] chunk_index;
      logic found;
      logic [1:0] status;
   } rsp_type;
endpackage

// ===== sv/schs_hash.sv =====
// ----------------------------------------------------------------------------
// schs_hash
// Bucket hash of a chunk coordinate: one multiply-add per cycle, then modulo.
// ----------------------------------------------------------------------------
module schs_hash import schs_pkg::*; #(
   parameter int HASH_SLOTS = 4096
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [31:0] x,
   input  logic [31:0] y,
   input  logic [31:0] z,
   output logic done,
   output logic [$clog2(HASH_SLOTS)-1:0] slot
);
   localparam int SlotBits = $clog2(HASH_SLOTS);
   localparam int SlotsPow2 = ((1 << SlotBits) == HASH_SLOTS) ? 1 : 0;
   localparam int QShift = 31 + SlotBits;
   // reciprocal of the slot count, exact for any 31-bit hash
   localparam logic [63:0] Recip = ((64'd1 << QShift) / 64'(HASH_SLOTS)) + 64'd1;

   logic [31:0] h_ff, h_in;
   logic [2:0] step_ff, step_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] term;
   logic [63:0] prod;

   always_comb begin
      case (step_ff)
         3'd1: term = x;
         3'd2: term = y;
         default: term = z;
      endcase
      prod = {33'd0, h_ff[30:0]} * {32'd0, Recip[31:0]};
   end

   always_comb begin
      h_in = h_ff;
      step_in = step_ff;
      rem_in = rem_ff;
      done = 1'b0;
      if (start) begin
         h_in = HashSeed;
         step_in = 3'd1;
      end else if (step_ff >= 3'd1 && step_ff <= 3'd3) begin
         h_in = h_ff * HashMul + term;
         step_in = step_ff + 3'd1;
         if (step_ff == 3'd3) begin
            h_in = (h_ff * HashMul + term) & HashMask;
            rem_in = '0;
            if (SlotsPow2 == 1) step_in = 3'd5;
         end
      end else if (step_ff == 3'd4) begin
         // quotient by reciprocal multiply
         rem_in = 32'(prod >> QShift);
         step_in = 3'd5;
      end else if (step_ff == 3'd5) begin
         if (SlotsPow2 == 1) rem_in = h_ff & 32'(HASH_SLOTS - 1);
         else rem_in = h_ff - rem_ff * 32'(HASH_SLOTS);
         step_in = 3'd6;
      end else if (step_ff == 3'd6) begin
         done = 1'b1;
         step_in = 3'd0;
      end
   end

   assign slot = rem_ff[SlotBits-1:0];

   always_ff @(posedge clock) begin
      if (reset) step_ff <= '0;
      else step_ff <= step_in;
      h_ff <= h_in;
      rem_ff <= rem_in;
   end
endmodule

// ===== sv/spatial_chunk_hash_store.sv =====
// ----------------------------------------------------------------------------
// spatial_chunk_hash_store
// Chained hash table of 3-D chunk coordinates with per-chunk entity blocks.
// ----------------------------------------------------------------------------
// A request transaction on req_ carries a kind in req_tuser (0 store, 1
// lookup) and the coordinates and entity word in req_tdata. One response
// transaction on rsp_ follows each request. The bucket hash comes first
// (with an extra reciprocal-multiply step for the remainder when HASH_SLOTS
// is not a power of two), then the bucket head read, then the chain walk,
// which reads and compares the key of each chunk visited. A lookup then goes
// through the decision and response states; a store adds the fill and write
// states, and a rejected store leaves for the response from the decision or
// fill state. One request is in flight at a time.
// After reset a clearing pass empties all HASH_SLOTS bucket heads;
// no request is taken during it. The response waits in an output register
// while rsp_tready is low, and the next request is taken only once it leaves.
// ----------------------------------------------------------------------------
module spatial_chunk_hash_store import schs_pkg::*; #(
   parameter int HASH_SLOTS = 4096,
   parameter int ENTITIES_PER_BLOCK = 16,
   parameter int MAX_CHUNKS = 1024,
   parameter int MAX_BLOCKS = 4096,
   parameter int ENTITY_BITS = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // chunk_x, chunk_y, chunk_z, entity_data
   input  logic [159:0] req_tdata,
   // req_type
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // status, found, chunk_index, block_index, entity_slot, new_chunk, new_block
   output logic [31:0] rsp_tdata
);
   localparam int SlotBits = $clog2(HASH_SLOTS);
   localparam int CkBits = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int BkBits = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int PosBits = (ENTITIES_PER_BLOCK > 1) ? $clog2(ENTITIES_PER_BLOCK) : 1;
   localparam int FillBits = $clog2(ENTITIES_PER_BLOCK + 1);
   localparam int CkCnt = $clog2(MAX_CHUNKS + 1);
   localparam int BkCnt = $clog2(MAX_BLOCKS + 1);
   localparam int EntDepth = MAX_BLOCKS * ENTITIES_PER_BLOCK;
   localparam int EntBits = $clog2(EntDepth) > 0 ? $clog2(EntDepth) : 1;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE = 4'd1;
   localparam logic [3:0] ST_HASH = 4'd2;
   localparam logic [3:0] ST_HEAD = 4'd3;
   localparam logic [3:0] ST_KEY = 4'd4;
   localparam logic [3:0] ST_CMP = 4'd5;
   localparam logic [3:0] ST_DEC = 4'd6;
   localparam logic [3:0] ST_FILL = 4'd7;
   localparam logic [3:0] ST_WRITE = 4'd8;
   localparam logic [3:0] ST_RSP = 4'd9;

   // memories
   logic [CkBits:0] head_mem [HASH_SLOTS];   // valid + chunk
   logic [3*CoordBits-1:0] key_mem [MAX_CHUNKS];
   logic [CkBits:0] link_mem [MAX_CHUNKS];
   logic [BkBits:0] newest_mem [MAX_CHUNKS];
   logic [BkBits:0] older_mem [MAX_BLOCKS];
   logic [FillBits-1:0] fill_mem [MAX_BLOCKS];
   logic [ENTITY_BITS-1:0] ent_mem [EntDepth];

   logic [3:0] state_ff, state_in;
   logic [SlotBits:0] clr_ff, clr_in;
   logic kind_ff, kind_in;
   logic [31:0] x_ff, y_ff, z_ff;
   logic [ENTITY_BITS-1:0] data_ff;
   logic [CkBits-1:0] cur_ff, cur_in;
   logic [CkCnt-1:0] chunks_ff, chunks_in;
   logic [BkCnt-1:0] blocks_ff, blocks_in;
   logic found_ff, found_in, empty_ff, empty_in;
   logic [CkCnt-1:0] hops_ff, hops_in;
   logic [CkBits:0] head_rd_ff, link_rd_ff;
   logic [3*CoordBits-1:0] key_rd_ff;
   logic [BkBits:0] newest_rd_ff;
   logic [FillBits-1:0] fill_rd_ff;
   rsp_type rsp_ff, rsp_in;
   logic rsp_v_ff, rsp_v_in;

   logic hash_start, hash_done;
   logic [SlotBits-1:0] slot;
   logic [SlotBits-1:0] slot_ff;
   logic accept;

   // write strobes
   logic head_we, key_we, link_we, newest_we, older_we, fill_we, ent_we;
   logic [SlotBits-1:0] head_wa;
   logic [CkBits:0] head_wd;
   logic [CkBits-1:0] link_wa, newest_wa;
   logic [CkBits:0] link_wd;
   logic [BkBits:0] newest_wd, older_wd;
   logic [BkBits-1:0] blk_wa;
   logic [FillBits-1:0] fill_wd;
   logic [EntBits-1:0] ent_wa;
   logic [BkBits-1:0] blk_c;
   logic [CkBits-1:0] chunk_c;

   schs_hash #(.HASH_SLOTS(HASH_SLOTS)) u_hash (
      .clock(clock), .reset(reset), .start(hash_start),
      .x(x_ff), .y(y_ff), .z(z_ff),
      .done(hash_done), .slot(slot)
   );

   assign req_tready = (state_ff == ST_IDLE) && !rsp_v_ff;
   assign accept = req_tvalid && req_tready;
   assign hash_start = accept;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata = {1'b0, rsp_ff};

   logic key_match;
   assign key_match = key_rd_ff == {z_ff, y_ff, x_ff};

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      kind_in = kind_ff;
      cur_in = cur_ff;
      chunks_in = chunks_ff;
      blocks_in = blocks_ff;
      found_in = found_ff;
      empty_in = empty_ff;
      hops_in = hops_ff;
      rsp_in = rsp_ff;
      rsp_v_in = rsp_v_ff && !rsp_tready;
      chunk_c = found_ff ? cur_ff : chunks_ff[CkBits-1:0];
      blk_c = (rsp_ff.new_block) ? blocks_ff[BkBits-1:0] - BkBits'(1)
                                 : newest_rd_ff[BkBits-1:0];
      head_we = 1'b0; head_wa = slot_ff; head_wd = '0;
      key_we = 1'b0; link_we = 1'b0; link_wa = cur_ff; link_wd = '0;
      newest_we = 1'b0; newest_wa = chunk_c; newest_wd = '0;
      older_we = 1'b0; older_wd = '0; fill_we = 1'b0; fill_wd = '0;
      ent_we = 1'b0;
      blk_wa = blk_c;
      ent_wa = EntBits'(blk_c * ENTITIES_PER_BLOCK) + EntBits'(fill_rd_ff);
      unique case (state_ff)
         ST_CLEAR: begin
            head_we = 1'b1;
            head_wa = clr_ff[SlotBits-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (SlotBits+1)'(HASH_SLOTS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_tuser;
               state_in = ST_HASH;
            end
         end
         ST_HASH: if (hash_done) state_in = ST_HEAD;
         ST_HEAD: begin
            // head read data now valid
            found_in = 1'b0;
            empty_in = !head_rd_ff[CkBits];
            cur_in = head_rd_ff[CkBits-1:0];
            hops_in = '0;
            rsp_in = '0;
            state_in = head_rd_ff[CkBits] ? ST_KEY : ST_DEC;
         end
         ST_KEY: state_in = ST_CMP;
         ST_CMP: begin
            if (key_match) begin
               found_in = 1'b1;
               state_in = ST_DEC;
            end else if (!link_rd_ff[CkBits] ||
                         hops_ff == CkCnt'(MAX_CHUNKS - 1)) begin
               state_in = ST_DEC;
            end else begin
               cur_in = link_rd_ff[CkBits-1:0];
               hops_in = hops_ff + 1'b1;
               state_in = ST_KEY;
            end
         end
         ST_DEC: begin
            // newest_rd_ff holds newest block of cur when found
            rsp_in = '0;
            rsp_in.found = found_ff;
            rsp_in.chunk_index = found_ff ? 10'(cur_ff) : 10'd0;
            state_in = ST_RSP;
            if (kind_ff == REQ_LOOKUP) begin
               if (!found_ff) rsp_in.status = STATUS_MISS;
            end else if (!found_ff && chunks_ff == CkCnt'(MAX_CHUNKS)) begin
               rsp_in.status = STATUS_CHUNK_FULL;
            end else if (!found_ff || !newest_rd_ff[BkBits]) begin
               if (blocks_ff == BkCnt'(MAX_BLOCKS)) rsp_in.status = STATUS_BLOCK_FULL;
               else state_in = ST_FILL;
            end else begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            // fill_rd_ff valid for newest block if any
            if (found_ff && newest_rd_ff[BkBits] &&
                fill_rd_ff >= FillBits'(ENTITIES_PER_BLOCK) &&
                blocks_ff == BkCnt'(MAX_BLOCKS)) begin
               rsp_in.status = STATUS_BLOCK_FULL;
               state_in = ST_RSP;
            end else begin
               if (!found_ff) begin
                  key_we = 1'b1;
                  link_we = 1'b1; link_wa = chunk_c; link_wd = '0;
                  if (empty_ff) begin
                     head_we = 1'b1; head_wd = {1'b1, chunk_c};
                  end
                  chunks_in = chunks_ff + 1'b1;
                  rsp_in.new_chunk = 1'b1;
               end
               if (!found_ff || !newest_rd_ff[BkBits] ||
                   fill_rd_ff >= FillBits'(ENTITIES_PER_BLOCK)) begin
                  older_we = 1'b1;
                  blk_wa = blocks_ff[BkBits-1:0];
                  older_wd = found_ff ? newest_rd_ff : '0;
                  newest_we = 1'b1;
                  newest_wd = {1'b1, blocks_ff[BkBits-1:0]};
                  blocks_in = blocks_ff + 1'b1;
                  rsp_in.new_block = 1'b1;
               end
               rsp_in.chunk_index = 10'(chunk_c);
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            // tail link of non-empty chain on new chunk
            if (rsp_ff.new_chunk && !empty_ff) begin
               link_we = 1'b1; link_wa = cur_ff;
               link_wd = {1'b1, chunks_ff[CkBits-1:0] - CkBits'(1)};
            end
            if (rsp_ff.new_block) fill_wd = FillBits'(1);
            else fill_wd = fill_rd_ff + 1'b1;
            fill_we = 1'b1;
            ent_we = 1'b1;
            if (rsp_ff.new_block) ent_wa = EntBits'(blk_c * ENTITIES_PER_BLOCK);
            rsp_in.block_index = 12'(blk_c);
            rsp_in.entity_slot = rsp_ff.new_block ? 4'd0 : 4'(fill_rd_ff);
            state_in = ST_RSP;
         end
         ST_RSP: begin
            rsp_v_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (hash_done) slot_ff <= slot;
      head_rd_ff <= head_mem[hash_done ? slot : slot_ff];
      if (head_we) head_mem[head_wa] <= head_wd;
      key_rd_ff <= key_mem[cur_ff];
      link_rd_ff <= link_mem[cur_ff];
      newest_rd_ff <= newest_mem[cur_ff];
      if (key_we) key_mem[chunk_c] <= {z_ff, y_ff, x_ff};
      if (link_we) link_mem[link_wa] <= link_wd;
      if (newest_we) newest_mem[newest_wa] <= newest_wd;
      fill_rd_ff <= fill_mem[newest_rd_ff[BkBits-1:0]];
      if (fill_we) fill_mem[blk_wa] <= fill_wd;
      if (older_we) older_mem[blk_wa] <= older_wd;
      if (ent_we) ent_mem[ent_wa] <= data_ff;
      if (accept) begin
         x_ff <= req_tdata[31:0];
         y_ff <= req_tdata[63:32];
         z_ff <= req_tdata[95:64];
         data_ff <= req_tdata[96 +: ENTITY_BITS];
      end
      cur_ff <= cur_in;
      found_ff <= found_in;
      empty_ff <= empty_in;
      hops_ff <= hops_in;
      kind_ff <= kind_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         chunks_ff <= '0;
         blocks_ff <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         chunks_ff <= chunks_in;
         blocks_ff <= blocks_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !accept) else $error("accept while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && !rsp_tready) |=> (rsp_v_ff && $stable(rsp_ff)))
      else $error("response changed under stall");
   a_chunk_bound: assert property (@(posedge clock) disable iff (reset)
      chunks_ff <= CkCnt'(MAX_CHUNKS)) else $error("chunk count overflow");
   a_block_bound: assert property (@(posedge clock) disable iff (reset)
      blocks_ff <= BkCnt'(MAX_BLOCKS)) else $error("block count overflow");
endmodule
